// ===== rtl/sm4_pkg.sv =====
package sm4_pkg;

   // Cipher geometry
   localparam int RoundCount = 32;
   localparam int WordWidth  = 32;
   localparam int BlockWidth = 128;
   localparam int HalfWidth  = 64;
   localparam int RoundIdxWidth = $clog2(RoundCount);

   // Configuration register indexes
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   // Commands
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [WordWidth-1:0] sm4_word_type;

   // One pipeline slot: x0 in the top word, x3 in the bottom word
   typedef struct packed {
      logic                  valid;
      logic                  dec;
      logic [BlockWidth-1:0] data;
   } sm4_stage_type;

   // System parameter FK
   localparam sm4_word_type Fk0 = 32'ha3b1bac6;
   localparam sm4_word_type Fk1 = 32'h56aa3350;
   localparam sm4_word_type Fk2 = 32'h677d9197;
   localparam sm4_word_type Fk3 = 32'hb27022dc;

   localparam logic [7:0] SboxTable [0:255] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic sm4_word_type rotl(input sm4_word_type v, input int n);
      rotl = (v << n) | (v >> (WordWidth - n));
   endfunction

   // Byte-wise S-box on a word
   function automatic sm4_word_type tau(input sm4_word_type v);
      tau = {SboxTable[v[31:24]], SboxTable[v[23:16]], SboxTable[v[15:8]], SboxTable[v[7:0]]};
   endfunction

   // Linear map of the data rounds
   function automatic sm4_word_type l_data(input sm4_word_type b);
      l_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   // Linear map of the key schedule
   function automatic sm4_word_type l_key(input sm4_word_type b);
      l_key = b ^ rotl(b, 13) ^ rotl(b, 23);
   endfunction

   // CK constant: byte j of word i is (4i + j) * 7 mod 256
   function automatic sm4_word_type ck_word(input logic [RoundIdxWidth-1:0] i);
      logic [7:0] base;
      base = {1'b0, i, 2'b00};
      ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
                 8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
   endfunction

endpackage

// ===== rtl/sm4_key_sched.sv =====
module sm4_key_sched (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   restart,
   input  logic [sm4_pkg::BlockWidth-1:0]         cipher_key,
   output logic                                   keys_ready,
   output sm4_pkg::sm4_word_type                  round_keys [sm4_pkg::RoundCount]
);
   import sm4_pkg::*;

   logic                     ready_ff, ready_in;
   logic                     busy_ff, busy_in;
   logic [RoundIdxWidth-1:0] count_ff, count_in;
   sm4_word_type             k_ff [4];
   sm4_word_type             k_in [4];
   sm4_word_type             rk_ff [RoundCount];
   sm4_word_type             new_key;

   // One key-schedule round per cycle
   assign new_key = k_ff[0] ^ l_key(tau(k_ff[1] ^ k_ff[2] ^ k_ff[3] ^ ck_word(count_ff)));

   // Sequencer: a key write restarts, then load, then 32 rounds
   always_comb begin
      ready_in = ready_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      k_in     = k_ff;
      if (restart) begin
         ready_in = 1'b0;
         busy_in  = 1'b0;
      end else if (busy_ff) begin
         k_in[0]  = k_ff[1];
         k_in[1]  = k_ff[2];
         k_in[2]  = k_ff[3];
         k_in[3]  = new_key;
         count_in = count_ff + 1'b1;
         if (count_ff == RoundIdxWidth'(RoundCount - 1)) begin
            busy_in  = 1'b0;
            ready_in = 1'b1;
         end
      end else if (!ready_ff) begin
         k_in[0]  = cipher_key[127:96] ^ Fk0;
         k_in[1]  = cipher_key[95:64]  ^ Fk1;
         k_in[2]  = cipher_key[63:32]  ^ Fk2;
         k_in[3]  = cipher_key[31:0]   ^ Fk3;
         count_in = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         ready_ff <= ready_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      k_ff     <= k_in;
      if (busy_ff && !restart) begin
         rk_ff[count_ff] <= new_key;
      end
   end

   assign keys_ready = ready_ff;
   assign round_keys = rk_ff;

endmodule

// ===== rtl/sm4_round_stage.sv =====
module sm4_round_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  sm4_pkg::sm4_stage_type stage_in,
   input  sm4_pkg::sm4_word_type  rk_fwd,
   input  sm4_pkg::sm4_word_type  rk_rev,
   output sm4_pkg::sm4_stage_type stage_out
);
   import sm4_pkg::*;

   logic                  valid_ff;
   logic                  dec_ff;
   logic [BlockWidth-1:0] data_ff, data_in;
   sm4_word_type          rk, x0, x1, x2, x3;

   assign x0 = stage_in.data[127:96];
   assign x1 = stage_in.data[95:64];
   assign x2 = stage_in.data[63:32];
   assign x3 = stage_in.data[31:0];

   // Key order follows the command
   assign rk = (stage_in.dec == CMD_DECRYPT) ? rk_rev : rk_fwd;

   // One round of F, words shift up by one
   assign data_in = {x1, x2, x3, x0 ^ l_data(tau(x1 ^ x2 ^ x3 ^ rk))};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff  <= stage_in.dec;
         data_ff <= data_in;
      end
   end

   assign stage_out = '{valid: valid_ff, dec: dec_ff, data: data_ff};

endmodule

// ===== rtl/sm4_block_cipher_unit.sv =====
// SM4 block cipher, electronic-codebook mode, one round per pipeline stage.
//
// Key: written through csr_write_enable / csr_index / csr_write_data, index
// 0 for the upper key half and 1 for the lower half; write only while idle.
// Each key write, and reset, starts a key expansion that computes one round
// key per cycle in the key schedule sequencer; req_stall stays high until
// it is done.
// Blocks: a transaction on req_ carries a command (0 encrypt, 1 decrypt)
// and a 128-bit block; one transaction per cycle can be taken while
// req_stall is low. The 32 rounds run in 32 register stages, the last of
// which drives rsp_, so results come out in order at up to one per cycle
// while rsp_stall is low.
// Reset clears all stage valid bits and the key (to zero), and marks the
// round keys stale.
// When the receiver raises rsp_stall with a result waiting, the whole
// pipeline holds and req_stall rises in the same cycle; nothing is dropped.
module sm4_block_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);
   import sm4_pkg::*;

   logic [HalfWidth-1:0] key_high_ff, key_low_ff;
   logic                 keys_ready;
   logic                 advance;
   sm4_word_type         round_keys [RoundCount];
   sm4_stage_type        stage [RoundCount+1];
   sm4_word_type         y0, y1, y2, y3;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_write_data;
            default:      ;
         endcase
      end
   end

   sm4_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write_enable),
      .cipher_key ({key_high_ff, key_low_ff}),
      .keys_ready (keys_ready),
      .round_keys (round_keys)
   );

   // Pipeline moves unless a finished result is held
   assign advance   = !stage[RoundCount].valid || !rsp_stall;
   assign req_stall = !keys_ready || !advance;

   assign stage[0].valid = req_valid && keys_ready;
   assign stage[0].dec   = req_command;
   assign stage[0].data  = {req_block_high, req_block_low};

   for (genvar i = 0; i < RoundCount; i++) begin : g_round
      sm4_round_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stage[i]),
         .rk_fwd    (round_keys[i]),
         .rk_rev    (round_keys[RoundCount-1-i]),
         .stage_out (stage[i+1])
      );
   end

   // Output is the last four words in reverse order
   assign y0 = stage[RoundCount].data[127:96];
   assign y1 = stage[RoundCount].data[95:64];
   assign y2 = stage[RoundCount].data[63:32];
   assign y3 = stage[RoundCount].data[31:0];

   assign rsp_valid       = stage[RoundCount].valid;
   assign rsp_result_high = {y3, y2};
   assign rsp_result_low  = {y1, y0};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   import sm4_pkg::*;

   // Receiver stall behavior, picked at random for stretches of cycles
   typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_type;

   // S-box, byte-wise substitution
   localparam logic [7:0] SboxBytes [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7, 8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3, 8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a, 8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95, 8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba, 8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b, 8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2, 8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52, 8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5, 8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55, 8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60, 8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f, 8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f, 8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd, 8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e, 8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20, 8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   localparam logic [31:0] FkWords [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

   // Published test vector: key and plaintext are the same value
   localparam logic [127:0] StdKey    = 128'h0123456789abcdeffedcba9876543210;
   localparam logic [127:0] StdCipher = 128'h681edf34d206965e86b3e94f536e4246;

   // DUT ports; the inputs are known from time zero
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_command      = 1'b0;
   logic [63:0] req_block_high   = '0;
   logic [63:0] req_block_low    = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = 1'b0;
   logic [63:0] csr_write_data   = '0;

   // Cipher state as the block should hold it
   logic [63:0]  key_high_q = '0;
   logic [63:0]  key_low_q  = '0;
   logic [31:0]  round_key_q [32];
   bit           round_keys_fresh = 1'b0;

   // Blocks expected back from the cipher, oldest first
   logic [127:0] cipher_out_q [$];

   int fail_count    = 0;
   int blocks_sent   = 0;
   int decrypts_sent = 0;
   int results_seen  = 0;
   int key_writes    = 0;
   int burst_left    = 0;
   int hold_request  = 0;

   sm4_block_cipher_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_block_high   (req_block_high),
      .req_block_low    (req_block_low),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_high  (rsp_result_high),
      .rsp_result_low   (rsp_result_low),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Cipher predictor
   // ---------------------------------------------------------------------
   function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [31:0] sub_bytes(input logic [31:0] v);
      return {SboxBytes[v[31:24]], SboxBytes[v[23:16]], SboxBytes[v[15:8]], SboxBytes[v[7:0]]};
   endfunction

   // Key schedule from the current key registers
   function automatic void expand_round_keys();
      logic [31:0] k [4];
      logic [31:0] ck;
      logic [31:0] t;
      logic [31:0] nk;
      k[0] = key_high_q[63:32] ^ FkWords[0];
      k[1] = key_high_q[31:0]  ^ FkWords[1];
      k[2] = key_low_q[63:32]  ^ FkWords[2];
      k[3] = key_low_q[31:0]   ^ FkWords[3];
      for (int i = 0; i < 32; i++) begin
         ck = {8'((4 * i) * 7), 8'((4 * i + 1) * 7), 8'((4 * i + 2) * 7), 8'((4 * i + 3) * 7)};
         t  = sub_bytes(k[1] ^ k[2] ^ k[3] ^ ck);
         nk = k[0] ^ t ^ rot_left(t, 13) ^ rot_left(t, 23);
         round_key_q[i] = nk;
         k[0] = k[1];
         k[1] = k[2];
         k[2] = k[3];
         k[3] = nk;
      end
      round_keys_fresh = 1'b1;
   endfunction

   // 32 rounds; decryption walks the round keys backward
   function automatic logic [127:0] sm4_crypt(input logic cmd, input logic [63:0] hi,
                                              input logic [63:0] lo);
      logic [31:0] x [4];
      logic [31:0] rk;
      logic [31:0] t;
      logic [31:0] nx;
      if (!round_keys_fresh)
         expand_round_keys();
      x[0] = hi[63:32];
      x[1] = hi[31:0];
      x[2] = lo[63:32];
      x[3] = lo[31:0];
      for (int i = 0; i < 32; i++) begin
         rk = (cmd == CMD_DECRYPT) ? round_key_q[31 - i] : round_key_q[i];
         t  = sub_bytes(x[1] ^ x[2] ^ x[3] ^ rk);
         nx = x[0] ^ t ^ rot_left(t, 2) ^ rot_left(t, 10) ^ rot_left(t, 18) ^ rot_left(t, 24);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = nx;
      end
      return {x[3], x[2], x[1], x[0]};
   endfunction

   // Biased 64-bit values: corners, walking bits, plain random
   function automatic logic [63:0] pick_word64();
      logic [63:0] one_hot;
      one_hot = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return one_hot;
         3:       return ~one_hot;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < 10)
         $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   logic [127:0] result_want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (cipher_out_q.size() == 0) begin
            note_failure($sformatf("unexpected result %h_%h", rsp_result_high, rsp_result_low));
         end else begin
            result_want = cipher_out_q.pop_front();
            if (rsp_result_high !== result_want[127:64])
               note_failure($sformatf("result_high exp %h got %h",
                                      result_want[127:64], rsp_result_high));
            if (rsp_result_low !== result_want[63:0])
               note_failure($sformatf("result_low exp %h got %h",
                                      result_want[63:0], rsp_result_low));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern of its own, plus long hold-offs on request
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode   = RX_FREE;
   int          mode_left = 0;
   int          hold_left = 0;
   int          rx_phase  = 0;

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      rx_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            RX_FREE:     rsp_stall <= 1'b0;
            RX_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
            RX_PERIODIC: rsp_stall <= ((rx_phase % 7) < 3);
            default:     rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sender side; every task starts and ends at a falling edge
   // ---------------------------------------------------------------------
   task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_block_high <= hi;
      req_block_low  <= lo;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      cipher_out_q.push_back(sm4_crypt(cmd, hi, lo));
      blocks_sent++;
      if (cmd == CMD_DECRYPT)
         decrypts_sent++;
      @(negedge clock);
      // bursts of back-to-back transactions with random gaps between
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // Sender pauses until every result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (cipher_out_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_key(input logic idx, input logic [63:0] value);
      // a key expansion still running keeps req_stall high
      while (req_stall)
         @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == CSR_KEY_HIGH)
         key_high_q = value;
      else
         key_low_q = value;
      round_keys_fresh = 1'b0;
      key_writes++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= {$urandom(), $urandom()};
      @(negedge clock);
   endtask

   task automatic write_full_key(input logic [127:0] key);
      write_key(CSR_KEY_HIGH, key[127:64]);
      write_key(CSR_KEY_LOW, key[63:0]);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Blocks before any key write use the reset key of zero
   task automatic test_reset_key();
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_DECRYPT, '0, '0);
      send_block(CMD_ENCRYPT, '1, '1);
      wait_idle();
   endtask

   // Published vector, also a check of the predictor itself
   task automatic test_standard_vector();
      logic [127:0] got;
      write_full_key(StdKey);
      got = sm4_crypt(CMD_ENCRYPT, StdKey[127:64], StdKey[63:0]);
      if (got !== StdCipher)
         note_failure($sformatf("predictor vector exp %h got %h", StdCipher, got));
      send_block(CMD_ENCRYPT, StdKey[127:64], StdKey[63:0]);
      send_block(CMD_DECRYPT, StdCipher[127:64], StdCipher[63:0]);
      wait_idle();
   endtask

   // Extreme keys and extreme blocks, both commands
   task automatic test_key_extremes();
      logic [127:0] keys [2];
      keys[0] = '1;
      keys[1] = {64'h0, 64'hffff_ffff_ffff_ffff};
      foreach (keys[i]) begin
         write_full_key(keys[i]);
         send_block(CMD_ENCRYPT, '0, '1);
         send_block(CMD_DECRYPT, '1, '0);
         send_block(CMD_ENCRYPT, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
         send_block(CMD_DECRYPT, 64'ha5a5_5a5a_a5a5_5a5a, 64'h5a5a_a5a5_5a5a_a5a5);
         wait_idle();
      end
   endtask

   // Writing only one half must still force a fresh key schedule
   task automatic test_half_key_update();
      write_key(CSR_KEY_LOW, 64'h0123_4567_89ab_cdef);
      send_block(CMD_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      send_block(CMD_DECRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      wait_idle();
      write_key(CSR_KEY_HIGH, 64'hfedc_ba98_7654_3210);
      send_block(CMD_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      send_block(CMD_DECRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      wait_idle();
   endtask

   // Long receiver hold-off while the sender keeps offering: pipeline fills
   task automatic test_output_backpressure();
      write_full_key({$urandom(), $urandom(), $urandom(), $urandom()});
      hold_request = 400;
      burst_left   = 200;
      repeat (80)
         send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                    pick_word64(), pick_word64());
      wait_idle();
   endtask

   // Random phases, each with its own key; many encrypt/decrypt round trips
   task automatic test_random_traffic(input int total);
      int           sent;
      int           phase_len;
      int           k;
      logic         cmd;
      logic [63:0]  hi;
      logic [63:0]  lo;
      logic [127:0] mid;
      sent = 0;
      while (sent < total) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0:       write_full_key('0);
            1:       write_full_key('1);
            2:       write_key(CSR_KEY_HIGH, pick_word64());
            3:       write_key(CSR_KEY_LOW, pick_word64());
            default: write_full_key({pick_word64(), pick_word64()});
         endcase
         phase_len = $urandom_range(100, 250);
         k = 0;
         while (k < phase_len && sent < total) begin
            cmd = $urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT;
            hi  = pick_word64();
            lo  = pick_word64();
            if ($urandom_range(0, 9) < 4) begin
               // round trip: the second block undoes the first
               mid = sm4_crypt(cmd, hi, lo);
               send_block(cmd, hi, lo);
               send_block((cmd == CMD_DECRYPT) ? CMD_ENCRYPT : CMD_DECRYPT,
                          mid[127:64], mid[63:0]);
               k    += 2;
               sent += 2;
            end else begin
               send_block(cmd, hi, lo);
               k++;
               sent++;
            end
         end
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int drain_cycles;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_key();
      test_standard_vector();
      test_key_extremes();
      test_half_key_update();
      test_output_backpressure();
      test_random_traffic(1500);

      // let any stray result show up, then account for leftovers
      drain_cycles = 0;
      while (cipher_out_q.size() != 0 && drain_cycles < 20000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (40) @(negedge clock);
      if (cipher_out_q.size() != 0)
         note_failure($sformatf("%0d results never arrived", cipher_out_q.size()));

      $display("Covered %0d blocks (%0d decrypt) over %0d key register writes,",
               blocks_sent, decrypts_sent, key_writes);
      $display("with random sender gaps and receiver stalls; %0d results checked, %0d errors.",
               results_seen, fail_count);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
